FILE: rtl/core/lbp_pkg.sv
package lbp_pkg;

  localparam int MAX_BYTES      = 4096;
  localparam int MAX_FIELD_BITS = 32;

  // Widest field the packer writes, and the largest buffer: MAX_BYTES, clipped to what the 13-bit register can name
  localparam int LIMIT_INT = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
  localparam int CAP_INT   = (MAX_BYTES > 8191) ? 8191 : MAX_BYTES;

  localparam logic [5:0]  LIMIT_BITS = LIMIT_INT[5:0];
  localparam logic [12:0] CAP_BYTES  = CAP_INT[12:0];
  localparam logic [12:0] RESET_BUFFER_BYTES = 13'd4096;

  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_PATCH  = 2'd1,
    REQ_ALIGN  = 2'd2
  } req_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // One classified request: a window of up to five bytes starting at addr
  typedef struct packed {
    logic [11:0] addr;
    logic [39:0] data;
    logic [39:0] mask;
    logic        status;
    logic [15:0] pos;
    logic [12:0] bytes;
    logic [2:0]  count;
  } lbp_desc_t;

endpackage

FILE: rtl/core/lbp_front.sv
module lbp_front import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] value,
  input  logic [5:0]  field_size,
  input  logic [15:0] bit_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        q_full,
  output logic        push,
  output lbp_desc_t   desc
);

  logic [12:0] buffer_bytes;
  logic [15:0] pos;
  logic [15:0] pos_next;

  req_t        req_kind;
  logic [5:0]  size_c;
  logic [12:0] cap;
  logic [15:0] cap_bits;
  logic [15:0] base;
  logic [16:0] end_sum;
  logic        over;
  logic [2:0]  shift;
  logic [32:0] smask_w;
  logic [31:0] smask;
  logic [39:0] win_mask;
  logic [39:0] win_data;
  logic [6:0]  nsum;
  logic [2:0]  nbytes;
  logic [2:0]  align_bit;
  logic        align_over;
  logic [7:0]  align_mask;
  logic [3:0]  align_step;
  logic [16:0] bw_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;

  always_comb begin
    req_kind = req_t'(req_type);
    size_c   = (field_size > LIMIT_BITS) ? LIMIT_BITS : field_size;
    cap      = (buffer_bytes > CAP_BYTES) ? CAP_BYTES : buffer_bytes;
    cap_bits = {cap, 3'b000};
    base     = (req_kind == REQ_APPEND) ? pos : bit_offset;
    end_sum  = {1'b0, base} + {11'b0, size_c};
    over     = end_sum > {1'b0, cap_bits};
    shift    = base[2:0];
    smask_w  = (33'd1 << size_c) - 33'd1;
    smask    = smask_w[31:0];
    win_mask = {8'b0, smask} << shift;
    win_data = {8'b0, value & smask} << shift;
    nsum     = {4'b0, shift} + {1'b0, size_c} + 7'd7;
    nbytes   = nsum[5:3];

    align_bit  = pos[2:0];
    align_over = pos[15:3] >= cap;
    align_mask = 8'hFF << align_bit;
    align_step = 4'd8 - {1'b0, align_bit};

    desc.addr   = '0;
    desc.data   = '0;
    desc.mask   = '0;
    desc.status = STATUS_OK;
    desc.count  = 3'd1;
    pos_next    = pos;

    case (req_kind)
      REQ_APPEND: begin
        if (size_c != 6'd0) begin
          if (over) begin
            desc.status = STATUS_OVERFLOW;
          end else begin
            desc.addr  = base[14:3];
            desc.data  = win_data;
            desc.mask  = win_mask;
            desc.count = nbytes;
            pos_next   = end_sum[15:0];
          end
        end
      end
      REQ_PATCH: begin
        // overflow wins over an empty patch
        if (over) begin
          desc.status = STATUS_OVERFLOW;
        end else if (size_c != 6'd0) begin
          desc.addr  = base[14:3];
          desc.data  = win_data;
          desc.mask  = win_mask;
          desc.count = nbytes;
        end
      end
      REQ_ALIGN: begin
        if (align_bit != 3'd0) begin
          if (align_over) begin
            desc.status = STATUS_OVERFLOW;
          end else begin
            desc.addr = pos[14:3];
            desc.mask = {32'b0, align_mask};
            pos_next  = pos + {12'b0, align_step};
          end
        end
      end
      default: ;
    endcase

    bw_sum     = {1'b0, pos_next} + 17'd7;
    desc.pos   = pos_next;
    desc.bytes = bw_sum[15:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      buffer_bytes <= RESET_BUFFER_BYTES;
    end else begin
      if (push) pos <= pos_next;
      if (cfg_valid) buffer_bytes <= cfg_data;
    end
  end

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(pos))
    else $error("bit position moved without a request");

endmodule

FILE: rtl/core/lbp_queue.sv
module lbp_queue import lbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lbp_desc_t din,
  input  logic      pop,
  output lbp_desc_t dout,
  output logic      full,
  output logic      not_empty
);

  lbp_desc_t  entries [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(Q_DEPTH));
  assign not_empty = (count != 2'd0);
  assign dout      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> count == 2'(Q_DEPTH))
    else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/lbp_back.sv
module lbp_back import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  lbp_desc_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] byte_address,
  output logic [7:0]  byte_data,
  output logic [7:0]  bit_mask,
  output logic        status,
  output logic [15:0] position_bits,
  output logic [12:0] bytes_written,
  output logic        last
);

  logic [2:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_data;
  logic [7:0] sel_mask;

  assign load    = q_valid && (!out_valid || out_ready);
  assign is_last = (idx == head.count - 3'd1);
  assign pop     = load && is_last;

  always_comb begin
    case (idx)
      3'd0:    begin sel_data = head.data[7:0];   sel_mask = head.mask[7:0];   end
      3'd1:    begin sel_data = head.data[15:8];  sel_mask = head.mask[15:8];  end
      3'd2:    begin sel_data = head.data[23:16]; sel_mask = head.mask[23:16]; end
      3'd3:    begin sel_data = head.data[31:24]; sel_mask = head.mask[31:24]; end
      3'd4:    begin sel_data = head.data[39:32]; sel_mask = head.mask[39:32]; end
      default: begin sel_data = 8'd0;             sel_mask = 8'd0;             end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_address  <= head.addr + {9'b0, idx};
      byte_data     <= sel_data;
      bit_mask      <= sel_mask;
      status        <= head.status;
      position_bits <= head.pos;
      bytes_written <= head.bytes;
      last          <= is_last;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (head.count != 3'd0) && (idx < head.count))
    else $error("byte index past request length");

  a_overflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_OVERFLOW) |-> (bit_mask == 8'd0) && last)
    else $error("overflow result carries a write");

endmodule

FILE: rtl/core/lsb_first_bit_packer_top.sv
// Path: a taken request is written into the queue, and its byte writes then leave the output register.
// Throughput: one request per cycle into a two-entry queue while it is not full; the output stage
// emits one masked byte write per cycle while out_ready is high, so a request holds it for 1 to 5 writes.
// Sustained rate is set by the output stage: the number of bytes each request touches.
// Reset: bit position 0, buffer_bytes 4096, queue and output register empty.
module lsb_first_bit_packer_top import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] value,
  input  logic [5:0]  field_size,
  input  logic [15:0] bit_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] byte_address,
  output logic [7:0]  byte_data,
  output logic [7:0]  bit_mask,
  output logic        status,
  output logic [15:0] position_bits,
  output logic [12:0] bytes_written,
  output logic        last
);

  lbp_desc_t push_desc;
  lbp_desc_t head;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  lbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .value       (value),
    .field_size  (field_size),
    .bit_offset  (bit_offset),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .desc        (push_desc)
  );

  lbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_desc),
    .pop       (pop),
    .dout      (head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  lbp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_address  (byte_address),
    .byte_data     (byte_data),
    .bit_mask      (bit_mask),
    .status        (status),
    .position_bits (position_bits),
    .bytes_written (bytes_written),
    .last          (last)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import lbp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PER_PHASE = 120;

  typedef struct packed {
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic        status;
    logic [15:0] pos;
    logic [12:0] bytes;
    logic        last;
  } byte_write_t;

  class byte_write_tracker;
    logic [15:0] position;
    logic [12:0] buffer_bytes;
    byte_write_t pending_writes[$];
    int error_count;

    function new();
      position = '0;
      buffer_bytes = RESET_BUFFER_BYTES;
      error_count = 0;
    endfunction

    function int unsigned capacity_bits();
      int unsigned b;
      b = buffer_bytes;
      if (b > MAX_BYTES) b = MAX_BYTES;
      return b * 8;
    endfunction

    // Position fields always carry the position after the request
    function void push_write(logic [11:0] addr, logic [7:0] data, logic [7:0] mask,
                             logic st, logic fin);
      byte_write_t w;
      w.addr = addr;
      w.data = data;
      w.mask = mask;
      w.status = st;
      w.pos = position;
      w.bytes = 13'((position + 7) / 8);
      w.last = fin;
      pending_writes.push_back(w);
    endfunction

    function void predict_field(logic [31:0] data, int unsigned size, int unsigned offset);
      logic [63:0] field_mask;
      logic [63:0] field_bits;
      int unsigned shift;
      int unsigned nbytes;
      int unsigned j;
      shift = offset % 8;
      field_mask = (64'd1 << size) - 64'd1;
      field_bits = ({32'd0, data} & field_mask) << shift;
      field_mask = field_mask << shift;
      nbytes = (shift + size + 7) / 8;
      for (j = 0; j < nbytes; j++)
        push_write(12'(offset / 8 + j), field_bits[8*j +: 8], field_mask[8*j +: 8],
                   STATUS_OK, j == nbytes - 1);
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] data, logic [5:0] size_in,
                               logic [15:0] offset);
      int unsigned cap;
      int unsigned size;
      int unsigned start;
      int unsigned tail;
      cap = capacity_bits();
      size = (size_in > LIMIT_BITS) ? LIMIT_BITS : size_in;
      case (kind)
        REQ_APPEND: begin
          if (size == 0) push_write('0, '0, '0, STATUS_OK, 1'b1);
          else if (position + size > cap) push_write('0, '0, '0, STATUS_OVERFLOW, 1'b1);
          else begin
            start = position;
            position = 16'(position + size);
            predict_field(data, size, start);
          end
        end
        REQ_PATCH: begin
          // range check comes ahead of the empty check
          if (offset + size > cap) push_write('0, '0, '0, STATUS_OVERFLOW, 1'b1);
          else if (size == 0) push_write('0, '0, '0, STATUS_OK, 1'b1);
          else predict_field(data, size, offset);
        end
        REQ_ALIGN: begin
          tail = position % 8;
          start = position / 8;
          if (tail == 0) push_write('0, '0, '0, STATUS_OK, 1'b1);
          else if (start >= cap / 8) push_write('0, '0, '0, STATUS_OVERFLOW, 1'b1);
          else begin
            position = 16'(position + 8 - tail);
            push_write(12'(start), '0, 8'hFF << tail, STATUS_OK, 1'b1);
          end
        end
        default: push_write('0, '0, '0, STATUS_OK, 1'b1);
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_result(byte_write_t got);
      byte_write_t want;
      if (pending_writes.size() == 0)
        report_mismatch($sformatf("unexpected write addr=%0d data=%h mask=%h st=%0d",
                                  got.addr, got.data, got.mask, got.status));
      else begin
        want = pending_writes.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "got a=%0d d=%h m=%h s=%0d p=%0d b=%0d l=%0d want a=%0d d=%h m=%h s=%0d p=%0d b=%0d l=%0d",
            got.addr, got.data, got.mask, got.status, got.pos, got.bytes, got.last,
            want.addr, want.data, want.mask, want.status, want.pos, want.bytes, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [31:0] value = '0;
  logic [5:0]  field_size = '0;
  logic [15:0] bit_offset = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] byte_address;
  logic [7:0]  byte_data;
  logic [7:0]  bit_mask;
  logic        status;
  logic [15:0] position_bits;
  logic [12:0] bytes_written;
  logic        last;

  int send_idle_pct = 30;
  int recv_idle_pct = 71;
  int cycle_count = 0;
  byte_write_tracker sb = new();

  lsb_first_bit_packer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .value        (value),
    .field_size   (field_size),
    .bit_offset   (bit_offset),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_address (byte_address),
    .byte_data    (byte_data),
    .bit_mask     (bit_mask),
    .status       (status),
    .position_bits(position_bits),
    .bytes_written(bytes_written),
    .last         (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({byte_address, byte_data, bit_mask, status, position_bits,
                       bytes_written, last});
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAIL lsb_first_bit_packer_top");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_request(input logic [1:0] kind, input logic [31:0] data,
                              input logic [5:0] size, input logic [15:0] offset);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    value <= data;
    field_size <= size;
    bit_offset <= offset;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, data, size, offset);
    @(negedge clk);
  endtask

  task automatic write_buffer_size(input logic [12:0] size_bytes);
    in_valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= size_bytes;
    do @(posedge clk); while (!cfg_ready);
    sb.buffer_bytes = size_bytes;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned cap;
    logic [1:0] kind;
    logic [5:0] size;
    logic [15:0] offset;
    pick = $urandom_range(0, 99);
    kind = (pick < 50) ? REQ_APPEND : (pick < 75) ? REQ_PATCH :
           (pick < 95) ? REQ_ALIGN : REQ_UNUSED;
    pick = $urandom_range(0, 99);
    size = (pick < 5) ? 6'd0 : (pick < 12) ? 6'($urandom_range(33, 63)) :
           6'($urandom_range(1, 32));
    cap = sb.capacity_bits();
    // keep most patches inside the buffer
    if (kind == REQ_PATCH && cap > 0 && $urandom_range(0, 99) < 85)
      offset = 16'($urandom_range(0, cap - 1));
    else
      offset = 16'($urandom);
    send_request(kind, $urandom, size, offset);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // one-byte buffer
    write_buffer_size(13'd1);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, 6'd5, 16'd0);
    send_request(REQ_APPEND, 32'h0000_000F, 6'd4, 16'd0);
    send_request(REQ_ALIGN, 32'd0, 6'd0, 16'd0);
    send_request(REQ_ALIGN, 32'd0, 6'd0, 16'd0);
    send_request(REQ_PATCH, 32'h0000_00A5, 6'd8, 16'd0);
    send_request(REQ_PATCH, 32'h0000_00A5, 6'd8, 16'd1);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);

    // empty buffer: anything that writes overflows
    write_buffer_size(13'd0);
    send_request(REQ_PATCH, 32'd1, 6'd0, 16'd0);
    send_request(REQ_PATCH, 32'd1, 6'd1, 16'd0);
    send_request(REQ_APPEND, 32'd1, 6'd1, 16'd0);
    send_request(REQ_APPEND, 32'd1, 6'd0, 16'd0);

    // register above the largest buffer saturates
    write_buffer_size(13'd8191);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, 6'd32, 16'd0);
    send_request(REQ_APPEND, 32'h0000_0001, 6'd1, 16'd0);
    send_request(REQ_APPEND, 32'hA5A5_A5A5, 6'd32, 16'd0);
    send_request(REQ_APPEND, $urandom, 6'd63, 16'd0);
    send_request(REQ_APPEND, 32'hFFFF_FFFF, 6'd3, 16'd0);
    send_request(REQ_PATCH, 32'hFFFF_FFFF, 6'd1, 16'd32767);
    send_request(REQ_PATCH, 32'hFFFF_FFFF, 6'd2, 16'd32767);
    send_request(REQ_PATCH, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
    send_request(REQ_PATCH, 32'h1234_5678, 6'd32, 16'd5);
    send_request(REQ_PATCH, 32'hDEAD_BEEF, 6'd40, 16'd7);

    // shrink the buffer below the current byte
    write_buffer_size(13'((sb.position / 8)));
    send_request(REQ_ALIGN, 32'd0, 6'd0, 16'd0);
    send_request(REQ_APPEND, 32'd1, 6'd1, 16'd0);

    write_buffer_size(13'd4096);
    repeat (RANDOM_PER_PHASE) send_random_request();

    send_idle_pct = 71;
    recv_idle_pct = 30;
    write_buffer_size(13'($urandom_range(4097, 8191)));
    repeat (RANDOM_PER_PHASE) send_random_request();

    // buffer end just ahead of the position
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_buffer_size(13'(sb.position / 8 + $urandom_range(2, 24)));
    repeat (RANDOM_PER_PHASE) send_random_request();

    in_valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.error_count == 0 && sb.pending_writes.size() == 0)
      $display("PASS lsb_first_bit_packer_top");
    else
      $display("FAIL lsb_first_bit_packer_top");
    $finish;
  end

endmodule

FILE: lsb_first_bit_packer_top.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_front.sv
rtl/core/lbp_queue.sv
rtl/core/lbp_back.sv
rtl/core/lsb_first_bit_packer_top.sv
verif/tb.sv
